// ===== hdl/tsaf_pkg.sv =====
package tsaf_pkg;

  // Interlock modes, same codes as the mode and previous_mode result fields
  typedef enum logic [2:0] {
    MODE_DISARMED = 3'd0,
    MODE_READY    = 3'd1,
    MODE_ARMED    = 3'd2,
    MODE_FALLEN   = 3'd3,
    MODE_LOWBAT   = 3'd4
  } mode_e;

  // Configuration register map (word index into the APB window)
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_FALL_ANGLE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_AUTO_ARM_EN    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_AUTO_ARM_ANGLE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TILT_TRIM      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ARM_HOLD       = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FALL_DEBOUNCE  = 3'd5;

  // Register reset values
  localparam int FALL_ANGLE_RST     = 4096;
  localparam int AUTO_ARM_ANGLE_RST = 410;
  localparam int ARM_HOLD_RST       = 100;
  localparam int FALL_DEBOUNCE_RST  = 20;

  // One result as it leaves the interlock logic
  typedef struct packed {
    mode_e mode;
    logic  drive_enable;
    logic  mode_changed;
    mode_e previous_mode;
  } result_t;

endpackage

// ===== hdl/tsaf_if.sv =====
interface tsaf_in_if #(
  parameter int ANGLE_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] tilt;
  logic                          imu_ready;
  logic                          battery_low;
  logic                          arm_request;
  logic                          disarm_request;
  logic                          reset_request;

  modport source (
    output valid, tilt, imu_ready, battery_low, arm_request, disarm_request, reset_request,
    input  ready
  );
  modport sink (
    input  valid, tilt, imu_ready, battery_low, arm_request, disarm_request, reset_request,
    output ready
  );
endinterface

interface tsaf_out_if ();
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       drive_enable;
  logic       mode_changed;
  logic [2:0] previous_mode;

  modport source (
    output valid, mode, drive_enable, mode_changed, previous_mode,
    input  ready
  );
  modport sink (
    input  valid, mode, drive_enable, mode_changed, previous_mode,
    output ready
  );
endinterface

// ===== hdl/tsaf_cfg.sv =====
module tsaf_cfg
  import tsaf_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  output logic [ANGLE_WIDTH-2:0] fall_angle_o,
  output logic                   auto_arm_enable_o,
  output logic [ANGLE_WIDTH-2:0] auto_arm_angle_o,
  output logic [ANGLE_WIDTH-1:0] tilt_trim_o,
  output logic [COUNT_WIDTH-1:0] auto_arm_hold_ticks_o,
  output logic [COUNT_WIDTH-1:0] fall_debounce_ticks_o
);

  localparam int MagW = ANGLE_WIDTH - 1;

  logic [MagW-1:0]        fall_angle_q;
  logic                   auto_arm_enable_q;
  logic [MagW-1:0]        auto_arm_angle_q;
  logic [ANGLE_WIDTH-1:0] tilt_trim_q;
  logic [COUNT_WIDTH-1:0] arm_hold_q;
  logic [COUNT_WIDTH-1:0] fall_debounce_q;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_angle_q      <= MagW'(FALL_ANGLE_RST);
      auto_arm_enable_q <= 1'b0;
      auto_arm_angle_q  <= MagW'(AUTO_ARM_ANGLE_RST);
      tilt_trim_q       <= '0;
      arm_hold_q        <= COUNT_WIDTH'(ARM_HOLD_RST);
      fall_debounce_q   <= COUNT_WIDTH'(FALL_DEBOUNCE_RST);
    end else if (wr_en) begin
      case (reg_idx)
        REG_FALL_ANGLE:     fall_angle_q      <= pwdata[MagW-1:0];
        REG_AUTO_ARM_EN:    auto_arm_enable_q <= pwdata[0];
        REG_AUTO_ARM_ANGLE: auto_arm_angle_q  <= pwdata[MagW-1:0];
        REG_TILT_TRIM:      tilt_trim_q       <= pwdata[ANGLE_WIDTH-1:0];
        REG_ARM_HOLD:       arm_hold_q        <= pwdata[COUNT_WIDTH-1:0];
        REG_FALL_DEBOUNCE:  fall_debounce_q   <= pwdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_FALL_ANGLE:     prdata = APB_DATA_W'(fall_angle_q);
      REG_AUTO_ARM_EN:    prdata = APB_DATA_W'(auto_arm_enable_q);
      REG_AUTO_ARM_ANGLE: prdata = APB_DATA_W'(auto_arm_angle_q);
      REG_TILT_TRIM:      prdata = APB_DATA_W'(tilt_trim_q);
      REG_ARM_HOLD:       prdata = APB_DATA_W'(arm_hold_q);
      REG_FALL_DEBOUNCE:  prdata = APB_DATA_W'(fall_debounce_q);
      default:            prdata = '0;
    endcase
  end

  assign fall_angle_o          = fall_angle_q;
  assign auto_arm_enable_o     = auto_arm_enable_q;
  assign auto_arm_angle_o      = auto_arm_angle_q;
  assign tilt_trim_o           = tilt_trim_q;
  assign auto_arm_hold_ticks_o = arm_hold_q;
  assign fall_debounce_ticks_o = fall_debounce_q;

endmodule

// ===== hdl/tsaf_step.sv =====
module tsaf_step
  import tsaf_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic signed [ANGLE_WIDTH-1:0] tilt_i,
  input  logic                          imu_ready_i,
  input  logic                          battery_low_i,
  input  logic                          arm_request_i,
  input  logic                          disarm_request_i,
  input  logic                          reset_request_i,
  input  logic [ANGLE_WIDTH-2:0]        fall_angle_i,
  input  logic                          auto_arm_enable_i,
  input  logic [ANGLE_WIDTH-2:0]        auto_arm_angle_i,
  input  logic [ANGLE_WIDTH-1:0]        tilt_trim_i,
  input  logic [COUNT_WIDTH-1:0]        auto_arm_hold_ticks_i,
  input  logic [COUNT_WIDTH-1:0]        fall_debounce_ticks_i,
  output result_t                       result_o
);

  localparam int WideW = ANGLE_WIDTH + 1;

  mode_e                  mode_q, mode_d;
  logic [COUNT_WIDTH-1:0] fall_cnt_q, fall_cnt_d, fall_cnt_nx;
  logic                   fall_act_q, fall_act_d;
  logic [COUNT_WIDTH-1:0] arm_cnt_q, arm_cnt_d, arm_cnt_nx;
  logic                   arm_act_q, arm_act_d;
  logic                   inhibit_q, inhibit_d;

  logic signed [WideW-1:0] tilt_x, trim_x, eff_x;
  logic [WideW-1:0]        tilt_abs, eff_abs;
  logic                    ready_ok, in_window, beyond;
  logic                    arm_track, arm_hit, fall_track, fall_hit, arm_now;

  // Magnitudes, all exact at one bit wider than the angle
  assign tilt_x   = WideW'(tilt_i);
  assign trim_x   = WideW'($signed(tilt_trim_i));
  assign eff_x    = tilt_x - trim_x;
  assign tilt_abs = tilt_x[WideW-1] ? WideW'(-tilt_x) : WideW'(tilt_x);
  assign eff_abs  = eff_x[WideW-1] ? WideW'(-eff_x) : WideW'(eff_x);

  assign ready_ok  = imu_ready_i && !battery_low_i
                     && ({tilt_abs, 1'b0} <= (WideW + 1)'(fall_angle_i));
  assign in_window = eff_abs <= WideW'(auto_arm_angle_i);
  assign beyond    = tilt_abs > WideW'(fall_angle_i);

  // Saturating dwell counts; a fresh dwell starts at zero
  assign arm_cnt_nx  = !arm_act_q ? '0 : ((arm_cnt_q == '1) ? arm_cnt_q : arm_cnt_q + 1'b1);
  assign fall_cnt_nx = !fall_act_q ? '0
                     : ((fall_cnt_q == '1) ? fall_cnt_q : fall_cnt_q + 1'b1);

  assign arm_track  = (mode_q == MODE_READY) && ready_ok && !arm_request_i && auto_arm_enable_i;
  assign arm_hit    = arm_track && in_window && !inhibit_q
                      && (arm_cnt_nx >= auto_arm_hold_ticks_i);
  assign fall_track = (mode_q == MODE_ARMED) && !battery_low_i && beyond;
  assign fall_hit   = fall_track && (fall_cnt_nx >= fall_debounce_ticks_i);
  assign arm_now    = (mode_q == MODE_READY) && ready_ok && (arm_request_i || arm_hit);

  // Next mode
  always_comb begin
    mode_d = mode_q;
    unique case (mode_q)
      MODE_DISARMED: begin
        if (ready_ok) mode_d = MODE_READY;
      end
      MODE_READY: begin
        priority if (!ready_ok) mode_d = MODE_DISARMED;
        else if (arm_now)       mode_d = MODE_ARMED;
      end
      MODE_ARMED: begin
        priority if (battery_low_i) mode_d = MODE_LOWBAT;
        else if (fall_hit)          mode_d = MODE_FALLEN;
        else if (disarm_request_i)  mode_d = MODE_DISARMED;
      end
      MODE_FALLEN, MODE_LOWBAT: begin
        if (reset_request_i) mode_d = MODE_DISARMED;
      end
      default: mode_d = mode_q;
    endcase
  end

  // Dwell timers and auto-arm inhibit
  always_comb begin
    fall_cnt_d = fall_cnt_q;
    fall_act_d = fall_act_q;
    arm_cnt_d  = arm_cnt_q;
    arm_act_d  = arm_act_q;
    inhibit_d  = inhibit_q;

    if (arm_now) begin
      fall_cnt_d = '0;
      fall_act_d = 1'b0;
      arm_cnt_d  = '0;
      arm_act_d  = 1'b0;
    end else if (arm_track) begin
      if (!in_window) begin
        arm_cnt_d = '0;
        arm_act_d = 1'b0;
        inhibit_d = 1'b0;
      end else if (!inhibit_q) begin
        arm_cnt_d = arm_cnt_nx;
        arm_act_d = 1'b1;
      end
    end else if ((mode_q == MODE_READY) && ready_ok && !arm_request_i) begin
      arm_cnt_d = '0;
      arm_act_d = 1'b0;
    end

    if ((mode_q == MODE_ARMED) && !battery_low_i) begin
      if (beyond) begin
        fall_cnt_d = fall_cnt_nx;
        fall_act_d = 1'b1;
      end else begin
        fall_cnt_d = '0;
        fall_act_d = 1'b0;
      end
    end

    // Every entry to disarmed re-arms the inhibit
    if ((mode_d == MODE_DISARMED) && (mode_q != MODE_DISARMED)) begin
      inhibit_d = 1'b1;
      arm_cnt_d = '0;
      arm_act_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_DISARMED;
      fall_cnt_q <= '0;
      fall_act_q <= 1'b0;
      arm_cnt_q  <= '0;
      arm_act_q  <= 1'b0;
      inhibit_q  <= 1'b1;
    end else if (step_i) begin
      mode_q     <= mode_d;
      fall_cnt_q <= fall_cnt_d;
      fall_act_q <= fall_act_d;
      arm_cnt_q  <= arm_cnt_d;
      arm_act_q  <= arm_act_d;
      inhibit_q  <= inhibit_d;
    end
  end

  assign result_o.mode          = mode_d;
  assign result_o.drive_enable  = (mode_d == MODE_ARMED);
  assign result_o.mode_changed  = (mode_d != mode_q);
  assign result_o.previous_mode = mode_q;

endmodule

// ===== hdl/tilt_safety_arming_fsm.sv =====
// Tilt safety interlock, one safety tick per transfer.
// Each tick is held in the input register, then its result is registered in the result register
// and presented on the output channel.
// Throughput: one tick per cycle unless the result side stalls; the mode and dwell state update per tick.
// Reset: mode disarmed, dwell timers cleared, auto-arm inhibited, registers at their
// defaults, both pipeline registers empty.
module tilt_safety_arming_fsm
  import tsaf_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tsaf_in_if.sink               in_i,
  tsaf_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [ANGLE_WIDTH-2:0] fall_angle;
  logic                   auto_arm_enable;
  logic [ANGLE_WIDTH-2:0] auto_arm_angle;
  logic [ANGLE_WIDTH-1:0] tilt_trim;
  logic [COUNT_WIDTH-1:0] auto_arm_hold_ticks;
  logic [COUNT_WIDTH-1:0] fall_debounce_ticks;

  logic                          in_valid_q;
  logic signed [ANGLE_WIDTH-1:0] tilt_q;
  logic                          imu_ready_q, battery_low_q;
  logic                          arm_req_q, disarm_req_q, reset_req_q;
  logic                          out_valid_q;
  result_t                       res_d, res_q;
  logic                          advance;

  tsaf_cfg #(
    .ANGLE_WIDTH(ANGLE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_cfg (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .fall_angle_o         (fall_angle),
    .auto_arm_enable_o    (auto_arm_enable),
    .auto_arm_angle_o     (auto_arm_angle),
    .tilt_trim_o          (tilt_trim),
    .auto_arm_hold_ticks_o(auto_arm_hold_ticks),
    .fall_debounce_ticks_o(fall_debounce_ticks)
  );

  // Move the held tick into the result register when that slot is free or is being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      tilt_q        <= in_i.tilt;
      imu_ready_q   <= in_i.imu_ready;
      battery_low_q <= in_i.battery_low;
      arm_req_q     <= in_i.arm_request;
      disarm_req_q  <= in_i.disarm_request;
      reset_req_q   <= in_i.reset_request;
    end
  end

  tsaf_step #(
    .ANGLE_WIDTH(ANGLE_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .step_i               (advance),
    .tilt_i               (tilt_q),
    .imu_ready_i          (imu_ready_q),
    .battery_low_i        (battery_low_q),
    .arm_request_i        (arm_req_q),
    .disarm_request_i     (disarm_req_q),
    .reset_request_i      (reset_req_q),
    .fall_angle_i         (fall_angle),
    .auto_arm_enable_i    (auto_arm_enable),
    .auto_arm_angle_i     (auto_arm_angle),
    .tilt_trim_i          (tilt_trim),
    .auto_arm_hold_ticks_i(auto_arm_hold_ticks),
    .fall_debounce_ticks_i(fall_debounce_ticks),
    .result_o             (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.mode          = res_q.mode;
  assign out_o.drive_enable  = res_q.drive_enable;
  assign out_o.mode_changed  = res_q.mode_changed;
  assign out_o.previous_mode = res_q.previous_mode;

  // A held tick always reaches the result register
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced tick did not reach the result register");

  // A held tick is never dropped while the result side stalls
  a_hold_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("stalled tick lost from the input register");

  // Drive enable only in armed mode
  a_drive_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.drive_enable) |-> (res_q.mode == MODE_ARMED))
    else $error("drive enabled outside armed mode");

  // Change flag agrees with the two modes
  a_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.mode_changed == (res_q.mode != res_q.previous_mode)))
    else $error("mode change flag inconsistent");

endmodule

// ===== test/tilt_safety_arming_fsm_tb.sv =====
module tilt_safety_arming_fsm_tb;
  import tsaf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // One safety tick as offered on the input channel
  typedef struct {
    logic signed [15:0] tilt;
    logic               imu_ready;
    logic               battery_low;
    logic               arm_request;
    logic               disarm_request;
    logic               reset_request;
  } tick_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tsaf_in_if  in_if ();
  tsaf_out_if out_if ();

  tilt_safety_arming_fsm u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // Register shadow, tracks every write
  logic [14:0]        cfg_fall     = 15'(FALL_ANGLE_RST);
  logic               cfg_auto_en  = 1'b0;
  logic [14:0]        cfg_angle    = 15'(AUTO_ARM_ANGLE_RST);
  logic signed [15:0] cfg_trim     = 16'sd0;
  logic [15:0]        cfg_hold     = 16'(ARM_HOLD_RST);
  logic [15:0]        cfg_debounce = 16'(FALL_DEBOUNCE_RST);

  // Interlock state mirror
  mode_e       st_mode     = MODE_DISARMED;
  logic [15:0] fall_cnt    = '0;
  logic        fall_act    = 1'b0;
  logic [15:0] arm_cnt     = '0;
  logic        arm_act     = 1'b0;
  logic        arm_inhibit = 1'b1;

  result_t pending_results[$];

  int  burst_left    = 0;
  bit  gaps_on       = 1'b1;
  int  hold_off_left = 0;
  int  rx_cycle      = 0;
  int  rx_mode       = 0;
  int  cycle_count   = 0;
  int  ticks_sent    = 0;
  int  results_seen  = 0;
  int  reg_writes    = 0;
  int  err_count     = 0;
  int  mode_hits[5]  = '{default: 0};

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == COUNT_MAX) ? c : c + 16'd1;
  endfunction

  function automatic void clear_arm_dwells();
    fall_act = 1'b0;
    fall_cnt = '0;
    arm_act  = 1'b0;
    arm_cnt  = '0;
  endfunction

  // Advance the mirrored interlock by one tick and return the result it gives
  function automatic result_t step_interlock(input tick_t t);
    result_t r;
    mode_e   prev;
    mode_e   nxt;
    int      mag;
    bit      ready_ok;
    prev     = st_mode;
    nxt      = prev;
    mag      = magnitude(int'(t.tilt));
    ready_ok = t.imu_ready && !t.battery_low && (2 * mag <= int'(cfg_fall));
    case (prev)
      MODE_DISARMED: begin
        if (ready_ok) nxt = MODE_READY;
      end
      MODE_READY: begin
        if (!ready_ok) begin
          nxt = MODE_DISARMED;
        end else if (t.arm_request) begin
          clear_arm_dwells();
          nxt = MODE_ARMED;
        end else if (cfg_auto_en) begin
          if (magnitude(int'(t.tilt) - int'(cfg_trim)) <= int'(cfg_angle)) begin
            if (!arm_inhibit) begin
              if (!arm_act) begin
                arm_act = 1'b1;
                arm_cnt = '0;
              end else begin
                arm_cnt = sat_inc(arm_cnt);
              end
              if (arm_cnt >= cfg_hold) begin
                clear_arm_dwells();
                nxt = MODE_ARMED;
              end
            end
          end else begin
            arm_act     = 1'b0;
            arm_cnt     = '0;
            arm_inhibit = 1'b0;
          end
        end else begin
          arm_act = 1'b0;
          arm_cnt = '0;
        end
      end
      MODE_ARMED: begin
        if (t.battery_low) begin
          nxt = MODE_LOWBAT;
        end else begin
          if (mag > int'(cfg_fall)) begin
            if (!fall_act) begin
              fall_act = 1'b1;
              fall_cnt = '0;
            end else begin
              fall_cnt = sat_inc(fall_cnt);
            end
            if (fall_cnt >= cfg_debounce) nxt = MODE_FALLEN;
          end else begin
            fall_act = 1'b0;
            fall_cnt = '0;
          end
          if (nxt == MODE_ARMED && t.disarm_request) nxt = MODE_DISARMED;
        end
      end
      MODE_FALLEN, MODE_LOWBAT: begin
        if (t.reset_request) nxt = MODE_DISARMED;
      end
      default: ;
    endcase
    // Re-arm the inhibit on every entry to disarmed
    if (nxt != prev && nxt == MODE_DISARMED) begin
      arm_inhibit = 1'b1;
      arm_act     = 1'b0;
      arm_cnt     = '0;
    end
    st_mode         = nxt;
    r.mode          = nxt;
    r.drive_enable  = (nxt == MODE_ARMED);
    r.mode_changed  = (nxt != prev);
    r.previous_mode = prev;
    return r;
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Offer one tick in bursts with random gaps, record its result on transfer
  task automatic send_tick(input tick_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_if.valid          <= 1'b1;
    in_if.tilt           <= t.tilt;
    in_if.imu_ready      <= t.imu_ready;
    in_if.battery_low    <= t.battery_low;
    in_if.arm_request    <= t.arm_request;
    in_if.disarm_request <= t.disarm_request;
    in_if.reset_request  <= t.reset_request;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(step_interlock(t));
    burst_left--;
    ticks_sent++;
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_FALL_ANGLE:     cfg_fall     = val[14:0];
      REG_AUTO_ARM_EN:    cfg_auto_en  = val[0];
      REG_AUTO_ARM_ANGLE: cfg_angle    = val[14:0];
      REG_TILT_TRIM:      cfg_trim     = val[15:0];
      REG_ARM_HOLD:       cfg_hold     = val[15:0];
      REG_FALL_DEBOUNCE:  cfg_debounce = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  task automatic apply_config(input int fall, input bit auto_en, input int angle,
                              input int trim, input int hold, input int debounce);
    wait_idle();
    write_reg(REG_FALL_ANGLE, 32'(fall));
    write_reg(REG_AUTO_ARM_EN, 32'(auto_en));
    write_reg(REG_AUTO_ARM_ANGLE, 32'(angle));
    write_reg(REG_TILT_TRIM, {16'h0, 16'(trim)});
    write_reg(REG_ARM_HOLD, 32'(hold));
    write_reg(REG_FALL_DEBOUNCE, 32'(debounce));
  endtask

  // Stimulus helpers
  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic signed [15:0] clamp_tilt(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic tick_t make_tick(input int tilt, input bit imu, input bit lowbat,
                                      input bit arm, input bit disarm, input bit clr);
    tick_t t;
    t.tilt           = clamp_tilt(tilt);
    t.imu_ready      = imu;
    t.battery_low    = lowbat;
    t.arm_request    = arm;
    t.disarm_request = disarm;
    t.reset_request  = clr;
    return t;
  endfunction

  // Tilt that keeps the ready preconditions
  function automatic int calm_tilt();
    int half;
    half = int'(cfg_fall) / 2;
    if (half == 0) return 0;
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  // Tilt past the cutoff, half the time just past it
  function automatic int beyond_tilt();
    int mag;
    mag = int'(cfg_fall) + 1 +
          (chance(50) ? int'($urandom_range(0, 3)) : int'($urandom_range(0, 32768)));
    return chance(50) ? mag : -mag;
  endfunction

  function automatic int window_tilt();
    int a;
    int off;
    a = int'(cfg_angle);
    if (chance(25)) off = chance(50) ? a : -a;
    else off = (a == 0) ? 0 : int'($urandom_range(0, 2 * a)) - a;
    return int'(cfg_trim) + off;
  endfunction

  function automatic int outside_tilt();
    int d;
    d = int'(cfg_angle) + 1 + int'($urandom_range(0, 40));
    return int'(cfg_trim) + (chance(50) ? d : -d);
  endfunction

  function automatic tick_t noise_tick();
    tick_t t;
    t.tilt           = chance(50) ? 16'($urandom) : clamp_tilt(calm_tilt());
    t.imu_ready      = !chance(15);
    t.battery_low    = chance(10);
    t.arm_request    = chance(20);
    t.disarm_request = chance(20);
    t.reset_request  = chance(20);
    return t;
  endfunction

  // Scenario: arm by request, then tilt past the cutoff around the debounce length
  task automatic run_arm_and_fall();
    int span;
    int dip;
    repeat ($urandom_range(1, 3)) send_tick(make_tick(calm_tilt(), 1, 0, 0, 0, 0));
    send_tick(make_tick(calm_tilt(), !chance(5), 0, 1, chance(10), chance(10)));
    repeat ($urandom_range(0, 4))
      send_tick(make_tick(calm_tilt(), !chance(5), 0, chance(10), 0, chance(10)));
    span = (cfg_debounce > 30) ? $urandom_range(3, 30) : int'(cfg_debounce) + $urandom_range(0, 3);
    repeat (span) begin
      dip = chance(50) ? (chance(50) ? int'(cfg_fall) : -int'(cfg_fall)) : calm_tilt();
      send_tick(make_tick(chance(8) ? dip : beyond_tilt(), !chance(5), chance(3),
                          chance(5), chance(5), chance(5)));
    end
    repeat ($urandom_range(1, 2))
      send_tick(make_tick(calm_tilt(), 1, 0, chance(20), chance(20), !chance(20)));
  endtask

  // Scenario: clear the inhibit, then hold the trimmed tilt inside the window
  task automatic run_auto_arm();
    int span;
    repeat ($urandom_range(1, 2)) send_tick(make_tick(calm_tilt(), 1, 0, 0, 0, 0));
    repeat ($urandom_range(1, 2)) send_tick(make_tick(outside_tilt(), 1, 0, 0, 0, 0));
    span = (cfg_hold > 30) ? $urandom_range(3, 30) : int'(cfg_hold) + $urandom_range(0, 3);
    repeat (span)
      send_tick(make_tick(chance(6) ? outside_tilt() : window_tilt(), !chance(3), chance(2),
                          chance(3), chance(3), chance(3)));
    repeat ($urandom_range(0, 3)) send_tick(make_tick(calm_tilt(), 1, 0, 0, 0, 0));
    send_tick(make_tick(calm_tilt(), 1, 0, 0, 1, 0));
  endtask

  // Scenario: armed, battery drops, stray requests, then clear
  task automatic run_low_battery();
    send_tick(make_tick(calm_tilt(), 1, 0, 0, 0, 0));
    send_tick(make_tick(calm_tilt(), 1, 0, 1, 0, 0));
    repeat ($urandom_range(0, 3)) send_tick(make_tick(calm_tilt(), 1, 0, 0, 0, 0));
    send_tick(make_tick(chance(50) ? beyond_tilt() : calm_tilt(), chance(80), 1,
                        chance(30), chance(30), 0));
    repeat ($urandom_range(0, 3))
      send_tick(make_tick(beyond_tilt(), chance(50), chance(50), chance(50), chance(50), 0));
    send_tick(make_tick(calm_tilt(), 1, chance(30), 0, 0, 1));
  endtask

  task automatic run_phase(input int budget);
    int stop_at;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      gaps_on = chance(70);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: run_arm_and_fall();
        4, 5:       run_auto_arm();
        6:          run_low_battery();
        default:    repeat ($urandom_range(3, 10)) send_tick(noise_tick());
      endcase
    end
  endtask

  // Ready preconditions from disarmed, with the half-cutoff boundary
  task automatic test_ready_gating();
    send_tick(make_tick(-32768, 1, 0, 0, 0, 0));
    send_tick(make_tick(2048, 1, 0, 0, 0, 0));
    send_tick(make_tick(2049, 1, 0, 0, 0, 0));
    send_tick(make_tick(0, 0, 0, 1, 1, 1));
    send_tick(make_tick(0, 1, 1, 0, 0, 0));
    send_tick(make_tick(-2048, 1, 0, 0, 1, 1));
  endtask

  // Manual arm and the ways out of armed
  task automatic test_armed_exits();
    send_tick(make_tick(0, 1, 0, 1, 1, 1));
    send_tick(make_tick(32767, 1, 0, 0, 1, 0));
    send_tick(make_tick(0, 1, 0, 0, 0, 0));
    send_tick(make_tick(100, 1, 0, 1, 0, 0));
    send_tick(make_tick(-4096, 1, 0, 0, 0, 0));
    send_tick(make_tick(0, 1, 1, 0, 1, 0));
    send_tick(make_tick(0, 1, 0, 1, 1, 0));
    send_tick(make_tick(0, 1, 0, 0, 0, 1));
  endtask

  // Zero debounce: fall beats disarm, low battery beats fall
  task automatic test_fall_debounce();
    wait_idle();
    write_reg(REG_FALL_DEBOUNCE, 32'd0);
    send_tick(make_tick(0, 1, 0, 0, 0, 0));
    send_tick(make_tick(0, 1, 0, 1, 0, 0));
    send_tick(make_tick(-4097, 1, 0, 0, 1, 0));
    send_tick(make_tick(0, 1, 0, 0, 0, 1));
    send_tick(make_tick(0, 1, 0, 0, 0, 0));
    send_tick(make_tick(0, 1, 0, 1, 0, 0));
    send_tick(make_tick(-32768, 1, 1, 0, 0, 0));
    send_tick(make_tick(0, 1, 0, 0, 0, 1));
  endtask

  // Auto-arm waits for the inhibit to clear, zero hold arms at once
  task automatic test_auto_arm();
    wait_idle();
    write_reg(REG_AUTO_ARM_EN, 32'd1);
    write_reg(REG_ARM_HOLD, 32'd0);
    send_tick(make_tick(0, 1, 0, 0, 0, 0));
    send_tick(make_tick(0, 1, 0, 0, 0, 0));
    send_tick(make_tick(1000, 1, 0, 0, 0, 0));
    send_tick(make_tick(5, 1, 0, 0, 0, 0));
  endtask

  // Receiver holds off while the sender keeps offering ticks back to back
  task automatic test_output_stall();
    wait_idle();
    gaps_on = 1'b0;
    hold_off_left = 80;
    repeat (40) send_tick(noise_tick());
    wait_idle();
  endtask

  task automatic test_random_phases();
    apply_config(4096, 0, 410, 0, 100, 20);
    run_phase(300);
    apply_config(4096, 1, 410, 300, 5, 3);
    run_phase(300);
    apply_config(32767, 1, 32767, -32768, 0, 0);
    run_phase(250);
    apply_config(0, 1, 0, 32767, 65535, 65535);
    run_phase(250);
    repeat (3) begin
      apply_config($urandom_range(200, 12000), chance(80), $urandom_range(0, 1500),
                   int'($urandom_range(0, 2000)) - 1000, $urandom_range(0, 12),
                   $urandom_range(0, 12));
      run_phase(250);
    end
  endtask

  // Receiver stall pattern, with a counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_off_left > 0) begin
      out_if.ready <= 1'b0;
      hold_off_left--;
    end else begin
      if (rx_cycle % 150 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 9) >= 3);
        2:       out_if.ready <= ((rx_cycle % 7) >= 2);
        default: out_if.ready <= ($urandom_range(0, 9) >= 7);
      endcase
    end
    rx_cycle++;
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result: mode %0d prev %0d",
                             out_if.mode, out_if.previous_mode));
      end else begin
        want = pending_results.pop_front();
        if (out_if.mode !== want.mode || out_if.drive_enable !== want.drive_enable ||
            out_if.mode_changed !== want.mode_changed ||
            out_if.previous_mode !== want.previous_mode) begin
          note_error($sformatf({"mismatch on result %0d (expected/actual): mode %0d/%0d",
                                " drive %0b/%0b changed %0b/%0b prev %0d/%0d"},
                               results_seen, want.mode, out_if.mode, want.drive_enable,
                               out_if.drive_enable, want.mode_changed, out_if.mode_changed,
                               want.previous_mode, out_if.previous_mode));
        end
      end
      if (out_if.mode < 3'd5) mode_hits[out_if.mode]++;
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: cycle limit of %0d reached, %0d results outstanding",
               CYCLE_LIMIT, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int waited;
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.tilt           = '0;
    in_if.imu_ready      = 1'b0;
    in_if.battery_low    = 1'b0;
    in_if.arm_request    = 1'b0;
    in_if.disarm_request = 1'b0;
    in_if.reset_request  = 1'b0;
    out_if.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ready_gating();
    test_armed_exits();
    test_fall_debounce();
    test_auto_arm();
    test_output_stall();
    test_random_phases();

    // Drain, then allow for the two-stage pipeline
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));

    $display("Run: %0d ticks sent, %0d results checked, %0d register writes, %0d errors",
             ticks_sent, results_seen, reg_writes, err_count);
    $display("Modes seen: disarmed %0d, ready %0d, armed %0d, fallen %0d, low battery %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4]);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
